/* design/gmd_pkg.sv */
// Shared types and constants for the grid metric differencer.
`default_nettype none

package gmd_pkg;

  localparam int COORD_W = 32;
  localparam int DERIV_W = 33;
  localparam int DIM_W   = 7;
  localparam int IDX_W   = 6;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
  localparam logic [DIM_W-1:0] DIM_MIN   = 7'd3;

  localparam logic CFG_IDX_ROWS = 1'b0;
  localparam logic CFG_IDX_COLS = 1'b1;

  localparam logic REQ_STORE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    STAT_STORED = 2'd0,
    STAT_VALID  = 2'd1,
    STAT_CORNER = 2'd2,
    STAT_RANGE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RD4,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    ADDR_POINT,
    ADDR_KSI_HI,
    ADDR_KSI_LO,
    ADDR_ETA_HI,
    ADDR_ETA_LO
  } addr_sel_t;

  typedef struct packed {
    logic      latch;
    logic      mem_we;
    addr_sel_t addr_sel;
    logic      cap_hi;
    logic      calc_ksi;
    logic      calc_eta;
    logic      emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic range_err;
    logic store_req;
    logic corner;
  } dp_status_t;

endpackage

`default_nettype wire

/* design/gmd_controller.sv */
// Sequencer for store and query beats of the grid metric differencer.
`default_nettype none

module gmd_controller (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  gmd_pkg::dp_status_t  dp_status,
  output logic                 busy,
  output gmd_pkg::ctl_cmd_t    cmd
);

  gmd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gmd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.addr_sel = gmd_pkg::ADDR_POINT;
    busy         = (state_r != gmd_pkg::ST_IDLE);
    case (state_r)
      gmd_pkg::ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = gmd_pkg::ST_DECODE;
        end
      end
      gmd_pkg::ST_DECODE: begin
        if (dp_status.range_err || dp_status.corner && !dp_status.store_req) begin
          state_nxt = gmd_pkg::ST_EMIT;
        end else if (dp_status.store_req) begin
          cmd.mem_we = 1'b1;
          state_nxt  = gmd_pkg::ST_EMIT;
        end else begin
          // first neighbour read issued straight away
          cmd.addr_sel = gmd_pkg::ADDR_KSI_HI;
          state_nxt    = gmd_pkg::ST_RD1;
        end
      end
      gmd_pkg::ST_RD1: begin
        cmd.addr_sel = gmd_pkg::ADDR_KSI_LO;
        cmd.cap_hi   = 1'b1;
        state_nxt    = gmd_pkg::ST_RD2;
      end
      gmd_pkg::ST_RD2: begin
        cmd.addr_sel = gmd_pkg::ADDR_ETA_HI;
        cmd.calc_ksi = 1'b1;
        state_nxt    = gmd_pkg::ST_RD3;
      end
      gmd_pkg::ST_RD3: begin
        cmd.addr_sel = gmd_pkg::ADDR_ETA_LO;
        cmd.cap_hi   = 1'b1;
        state_nxt    = gmd_pkg::ST_RD4;
      end
      gmd_pkg::ST_RD4: begin
        cmd.calc_eta = 1'b1;
        state_nxt    = gmd_pkg::ST_EMIT;
      end
      gmd_pkg::ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = gmd_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gmd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/gmd_datapath.sv */
// Grid memory, neighbour addressing, differencing and result registers.
`default_nettype none

module gmd_datapath #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  gmd_pkg::ctl_cmd_t                     cmd,
  output gmd_pkg::dp_status_t                   dp_status,
  input  wire                                   cfg_we,
  input  wire  [0:0]                            cfg_index,
  input  wire  [gmd_pkg::DIM_W-1:0]             cfg_data,
  input  wire                                   in_req_type,
  input  wire  [gmd_pkg::IDX_W-1:0]             in_row_index,
  input  wire  [gmd_pkg::IDX_W-1:0]             in_col_index,
  input  wire  signed [gmd_pkg::COORD_W-1:0]    in_x_coord,
  input  wire  signed [gmd_pkg::COORD_W-1:0]    in_y_coord,
  output logic                                  out_valid,
  output logic signed [gmd_pkg::DERIV_W-1:0]    out_dx_dksi,
  output logic signed [gmd_pkg::DERIV_W-1:0]    out_dy_dksi,
  output logic signed [gmd_pkg::DERIV_W-1:0]    out_dx_deta,
  output logic signed [gmd_pkg::DERIV_W-1:0]    out_dy_deta,
  output logic [1:0]                            out_status
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = gmd_pkg::COORD_W;
  localparam int DW     = gmd_pkg::DERIV_W;
  localparam int NW     = gmd_pkg::DIM_W;
  localparam int IW     = gmd_pkg::IDX_W;

  // configuration
  logic [NW-1:0] rows_cfg_r, cols_cfg_r;
  logic [NW-1:0] rows_use, cols_use;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= gmd_pkg::DIM_RESET;
      cols_cfg_r <= gmd_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gmd_pkg::CFG_IDX_ROWS: rows_cfg_r <= cfg_data;
        gmd_pkg::CFG_IDX_COLS: cols_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rows_cfg_r < gmd_pkg::DIM_MIN) begin
      rows_use = gmd_pkg::DIM_MIN;
    end else if (int'(rows_cfg_r) > MAX_ROWS) begin
      rows_use = NW'(MAX_ROWS);
    end else begin
      rows_use = rows_cfg_r;
    end
    if (cols_cfg_r < gmd_pkg::DIM_MIN) begin
      cols_use = gmd_pkg::DIM_MIN;
    end else if (int'(cols_cfg_r) > MAX_COLS) begin
      cols_use = NW'(MAX_COLS);
    end else begin
      cols_use = cols_cfg_r;
    end
  end

  // request beat held for the whole operation
  logic          req_type_r;
  logic [IW-1:0] row_r, col_r;
  logic [CW-1:0] x_r, y_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_type_r <= in_req_type;
      row_r      <= in_row_index;
      col_r      <= in_col_index;
      x_r        <= in_x_coord;
      y_r        <= in_y_coord;
    end
  end

  logic [NW-1:0] row_ext, col_ext;
  logic r_first, r_last, c_first, c_last;

  assign row_ext = {1'b0, row_r};
  assign col_ext = {1'b0, col_r};
  assign r_first = (row_r == '0);
  assign c_first = (col_r == '0);
  assign r_last  = (row_ext == rows_use - NW'(1));
  assign c_last  = (col_ext == cols_use - NW'(1));

  assign dp_status.range_err = (row_ext >= rows_use) || (col_ext >= cols_use);
  assign dp_status.store_req = (req_type_r == gmd_pkg::REQ_STORE);
  assign dp_status.corner    = (r_first || r_last) && (c_first || c_last);

  // neighbour address selection
  logic [IW-1:0]     addr_row, addr_col;
  logic [ADDR_W-1:0] mem_addr;

  always_comb begin
    addr_row = row_r;
    addr_col = col_r;
    case (cmd.addr_sel)
      gmd_pkg::ADDR_POINT: ;
      gmd_pkg::ADDR_KSI_HI: begin
        if (r_first)     addr_row = IW'(1);
        else if (r_last) addr_row = row_r;
        else             addr_row = row_r + IW'(1);
      end
      gmd_pkg::ADDR_KSI_LO: begin
        if (r_first) addr_row = '0;
        else         addr_row = row_r - IW'(1);
      end
      gmd_pkg::ADDR_ETA_HI: begin
        if (c_first)     addr_col = IW'(1);
        else if (c_last) addr_col = col_r;
        else             addr_col = col_r + IW'(1);
      end
      gmd_pkg::ADDR_ETA_LO: begin
        if (c_first) addr_col = '0;
        else         addr_col = col_r - IW'(1);
      end
      default: ;
    endcase
  end

  assign mem_addr = ADDR_W'(int'(addr_row) * MAX_COLS + int'(addr_col));

  // single-port grid store, x in the upper half of each word
  logic [2*CW-1:0] grid_mem [DEPTH];
  logic [2*CW-1:0] rd_q;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      grid_mem[mem_addr] <= {x_r, y_r};
    end
    rd_q <= grid_mem[mem_addr];
  end

  // differencing: hi neighbour captured first, lo neighbour arrives on calc
  logic [CW-1:0]        hi_x_r, hi_y_r;
  logic signed [DW-1:0] diff_x, diff_y;
  logic signed [DW-1:0] dx_dksi_r, dy_dksi_r, dx_deta_r, dy_deta_r;
  logic                 ksi_inner, eta_inner;

  assign diff_x    = $signed({hi_x_r[CW-1], hi_x_r}) - $signed({rd_q[2*CW-1], rd_q[2*CW-1:CW]});
  assign diff_y    = $signed({hi_y_r[CW-1], hi_y_r}) - $signed({rd_q[CW-1], rd_q[CW-1:0]});
  assign ksi_inner = !r_first && !r_last;
  assign eta_inner = !c_first && !c_last;

  always_ff @(posedge clk) begin
    if (cmd.cap_hi) begin
      hi_x_r <= rd_q[2*CW-1:CW];
      hi_y_r <= rd_q[CW-1:0];
    end
    // interior points: central difference halved, floor via arithmetic shift
    if (cmd.calc_ksi) begin
      dx_dksi_r <= ksi_inner ? (diff_x >>> 1) : diff_x;
      dy_dksi_r <= ksi_inner ? (diff_y >>> 1) : diff_y;
    end
    if (cmd.calc_eta) begin
      dx_deta_r <= eta_inner ? (diff_x >>> 1) : diff_x;
      dy_deta_r <= eta_inner ? (diff_y >>> 1) : diff_y;
    end
  end

  // result beat
  gmd_pkg::status_t status_code;
  logic             metrics_ok;

  always_comb begin
    if (dp_status.range_err)      status_code = gmd_pkg::STAT_RANGE;
    else if (dp_status.store_req) status_code = gmd_pkg::STAT_STORED;
    else if (dp_status.corner)    status_code = gmd_pkg::STAT_CORNER;
    else                          status_code = gmd_pkg::STAT_VALID;
  end

  assign metrics_ok = (status_code == gmd_pkg::STAT_VALID);

  logic                 out_valid_r;
  logic signed [DW-1:0] out_dx_dksi_r, out_dy_dksi_r, out_dx_deta_r, out_dy_deta_r;
  logic [1:0]           out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_dx_dksi_r <= metrics_ok ? dx_dksi_r : '0;
      out_dy_dksi_r <= metrics_ok ? dy_dksi_r : '0;
      out_dx_deta_r <= metrics_ok ? dx_deta_r : '0;
      out_dy_deta_r <= metrics_ok ? dy_deta_r : '0;
      out_status_r  <= status_code;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_dx_dksi = out_dx_dksi_r;
  assign out_dy_dksi = out_dy_dksi_r;
  assign out_dx_deta = out_dx_deta_r;
  assign out_dy_deta = out_dy_deta_r;
  assign out_status  = out_status_r;

endmodule

`default_nettype wire

/* design/grid_metric_differencer.sv */
// After accept the sequencer runs DECODE and EMIT for a store, range error or corner, and
// DECODE, RD1-RD4, EMIT for a metrics query (four reads of the single-port grid memory);
// the result strobe follows EMIT. Beats never overlap: start is taken only in idle;
// busy rises once a beat is accepted and is low again when the result strobe shows.
// Reset: rst_n synchronous; sequencer idle, dims back to 64, grid contents undefined.
`default_nettype none

module grid_metric_differencer #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire  [0:0]                            cfg_index,
  input  wire  [gmd_pkg::DIM_W-1:0]             cfg_data,
  input  wire                                   start,
  output logic                                  busy,
  input  wire                                   in_req_type,
  input  wire  [gmd_pkg::IDX_W-1:0]             in_row_index,
  input  wire  [gmd_pkg::IDX_W-1:0]             in_col_index,
  input  wire  signed [gmd_pkg::COORD_W-1:0]    in_x_coord,
  input  wire  signed [gmd_pkg::COORD_W-1:0]    in_y_coord,
  output logic                                  out_valid,
  output logic signed [gmd_pkg::DERIV_W-1:0]    out_dx_dksi,
  output logic signed [gmd_pkg::DERIV_W-1:0]    out_dy_dksi,
  output logic signed [gmd_pkg::DERIV_W-1:0]    out_dx_deta,
  output logic signed [gmd_pkg::DERIV_W-1:0]    out_dy_deta,
  output logic [1:0]                            out_status
);

  gmd_pkg::ctl_cmd_t   cmd;
  gmd_pkg::dp_status_t dp_status;

  gmd_controller u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .dp_status (dp_status),
    .busy      (busy),
    .cmd       (cmd)
  );

  gmd_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .dp_status    (dp_status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_req_type  (in_req_type),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_x_coord   (in_x_coord),
    .in_y_coord   (in_y_coord),
    .out_valid    (out_valid),
    .out_dx_dksi  (out_dx_dksi),
    .out_dy_dksi  (out_dy_dksi),
    .out_dx_deta  (out_dx_deta),
    .out_dy_deta  (out_dy_deta),
    .out_status   (out_status)
  );

endmodule

`default_nettype wire

/* design/gmd_checker.sv */
// Port-level checks for the grid metric differencer, bound to the top level.
`default_nettype none

module gmd_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                start,
  input wire                                busy,
  input wire                                out_valid,
  input wire signed [gmd_pkg::DERIV_W-1:0]  out_dx_dksi,
  input wire signed [gmd_pkg::DERIV_W-1:0]  out_dy_dksi,
  input wire signed [gmd_pkg::DERIV_W-1:0]  out_dx_deta,
  input wire signed [gmd_pkg::DERIV_W-1:0]  out_dy_deta,
  input wire [1:0]                          out_status
);

  // an accepted beat keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // a result beat only shows once the block is free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // one result per beat, never back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // result strobe follows a busy period
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without preceding work");

  // derivatives are zero unless metrics are valid
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != gmd_pkg::STAT_VALID) |->
      (out_dx_dksi == '0) && (out_dy_dksi == '0) &&
      (out_dx_deta == '0) && (out_dy_deta == '0))
    else $error("non-zero derivative with non-valid status");

endmodule

bind grid_metric_differencer gmd_checker u_gmd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_dx_dksi (out_dx_dksi),
  .out_dy_dksi (out_dy_dksi),
  .out_dx_deta (out_dx_deta),
  .out_dy_deta (out_dy_deta),
  .out_status  (out_status)
);

`default_nettype wire

/* tb/sv/grid_metric_differencer_test.sv */
// Testbench for the grid metric differencer: grid stores, metric queries and result checks.
`timescale 1ns / 1ps

module grid_metric_differencer_test;

  localparam int ROWS_MAX    = 64;
  localparam int COLS_MAX    = 64;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [gmd_pkg::DERIV_W-1:0] dx_dksi;
    logic signed [gmd_pkg::DERIV_W-1:0] dy_dksi;
    logic signed [gmd_pkg::DERIV_W-1:0] dx_deta;
    logic signed [gmd_pkg::DERIV_W-1:0] dy_deta;
    gmd_pkg::status_t                   status;
  } metric_beat_t;

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_we;
  logic [0:0]                          cfg_index;
  logic [gmd_pkg::DIM_W-1:0]           cfg_data;
  logic                                start;
  logic                                busy;
  logic                                in_req_type;
  logic [gmd_pkg::IDX_W-1:0]           in_row_index;
  logic [gmd_pkg::IDX_W-1:0]           in_col_index;
  logic signed [gmd_pkg::COORD_W-1:0]  in_x_coord;
  logic signed [gmd_pkg::COORD_W-1:0]  in_y_coord;
  logic                                out_valid;
  logic signed [gmd_pkg::DERIV_W-1:0]  out_dx_dksi;
  logic signed [gmd_pkg::DERIV_W-1:0]  out_dy_dksi;
  logic signed [gmd_pkg::DERIV_W-1:0]  out_dx_deta;
  logic signed [gmd_pkg::DERIV_W-1:0]  out_dy_deta;
  logic [1:0]                          out_status;

  // Predictor state: grid contents, which points hold data, and the dimension registers
  logic signed [gmd_pkg::COORD_W-1:0] node_x [ROWS_MAX*COLS_MAX];
  logic signed [gmd_pkg::COORD_W-1:0] node_y [ROWS_MAX*COLS_MAX];
  bit                                 node_written [ROWS_MAX*COLS_MAX];
  logic [gmd_pkg::DIM_W-1:0]          rows_reg = gmd_pkg::DIM_RESET;
  logic [gmd_pkg::DIM_W-1:0]          cols_reg = gmd_pkg::DIM_RESET;

  metric_beat_t pending_metrics[$];
  int unsigned  sender_idle_pct = 0;
  int           items_sent      = 0;
  int           mismatch_count  = 0;
  int           phase_count     = 0;
  int           status_seen [4] = '{0, 0, 0, 0};

  grid_metric_differencer #(
    .MAX_ROWS(ROWS_MAX),
    .MAX_COLS(COLS_MAX)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_row_index(in_row_index),
    .in_col_index(in_col_index),
    .in_x_coord  (in_x_coord),
    .in_y_coord  (in_y_coord),
    .out_valid   (out_valid),
    .out_dx_dksi (out_dx_dksi),
    .out_dy_dksi (out_dy_dksi),
    .out_dx_deta (out_dx_deta),
    .out_dy_deta (out_dy_deta),
    .out_status  (out_status)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int dim_in_use(input logic [gmd_pkg::DIM_W-1:0] v, input int hi);
    if (v < gmd_pkg::DIM_MIN) return int'(gmd_pkg::DIM_MIN);
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic int rows_in_use();
    return dim_in_use(rows_reg, ROWS_MAX);
  endfunction

  function automatic int cols_in_use();
    return dim_in_use(cols_reg, COLS_MAX);
  endfunction

  function automatic int node_addr(input int r, input int c);
    return r * COLS_MAX + c;
  endfunction

  // Neighbour pair along one axis: one-sided on the first and last index, central elsewhere
  function automatic void diff_span(input int pos, input int lim,
                                    output int hi, output int lo, output bit centre);
    centre = 1'b0;
    if (pos == 0) begin
      hi = 1;
      lo = 0;
    end else if (pos == lim - 1) begin
      hi = pos;
      lo = pos - 1;
    end else begin
      hi = pos + 1;
      lo = pos - 1;
      centre = 1'b1;
    end
  endfunction

  function automatic bit in_range(input int r, input int c);
    return r < rows_in_use() && c < cols_in_use();
  endfunction

  function automatic bit is_corner(input int r, input int c);
    return (r == 0 || r == rows_in_use() - 1) && (c == 0 || c == cols_in_use() - 1);
  endfunction

  // True when a query here reads only points that already hold data
  function automatic bit query_ready(input int r, input int c);
    int hi, lo;
    bit centre;
    if (!in_range(r, c) || is_corner(r, c)) return 1'b1;
    diff_span(r, rows_in_use(), hi, lo, centre);
    if (!node_written[node_addr(hi, c)] || !node_written[node_addr(lo, c)]) return 1'b0;
    diff_span(c, cols_in_use(), hi, lo, centre);
    return node_written[node_addr(r, hi)] && node_written[node_addr(r, lo)];
  endfunction

  function automatic logic signed [gmd_pkg::DERIV_W-1:0] gradient(
      input bit on_y, input bit along_eta, input int r, input int c);
    int hi, lo, a_hi, a_lo;
    bit centre;
    logic signed [gmd_pkg::COORD_W-1:0] v_hi, v_lo;
    logic signed [gmd_pkg::DERIV_W-1:0] d;
    if (along_eta) begin
      diff_span(c, cols_in_use(), hi, lo, centre);
      a_hi = node_addr(r, hi);
      a_lo = node_addr(r, lo);
    end else begin
      diff_span(r, rows_in_use(), hi, lo, centre);
      a_hi = node_addr(hi, c);
      a_lo = node_addr(lo, c);
    end
    v_hi = on_y ? node_y[a_hi] : node_x[a_hi];
    v_lo = on_y ? node_y[a_lo] : node_x[a_lo];
    d = {v_hi[gmd_pkg::COORD_W-1], v_hi} - {v_lo[gmd_pkg::COORD_W-1], v_lo};
    // halving floors toward minus infinity
    return centre ? (d >>> 1) : d;
  endfunction

  function automatic metric_beat_t predict_metrics(input logic req,
                                                   input logic [gmd_pkg::IDX_W-1:0] row,
                                                   input logic [gmd_pkg::IDX_W-1:0] col,
                                                   input logic [gmd_pkg::COORD_W-1:0] x,
                                                   input logic [gmd_pkg::COORD_W-1:0] y);
    metric_beat_t m;
    int r, c;
    r = int'(row);
    c = int'(col);
    m = '0;
    if (!in_range(r, c)) begin
      m.status = gmd_pkg::STAT_RANGE;
    end else if (req == gmd_pkg::REQ_STORE) begin
      node_x[node_addr(r, c)] = x;
      node_y[node_addr(r, c)] = y;
      node_written[node_addr(r, c)] = 1'b1;
      m.status = gmd_pkg::STAT_STORED;
    end else if (is_corner(r, c)) begin
      m.status = gmd_pkg::STAT_CORNER;
    end else begin
      m.dx_dksi = gradient(1'b0, 1'b0, r, c);
      m.dy_dksi = gradient(1'b1, 1'b0, r, c);
      m.dx_deta = gradient(1'b0, 1'b1, r, c);
      m.dy_deta = gradient(1'b1, 1'b1, r, c);
      m.status  = gmd_pkg::STAT_VALID;
    end
    return m;
  endfunction

  function automatic logic [gmd_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic req, input int r, input int c,
                           input logic [gmd_pkg::COORD_W-1:0] x,
                           input logic [gmd_pkg::COORD_W-1:0] y);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start        <= 1'b1;
    in_req_type  <= req;
    in_row_index <= gmd_pkg::IDX_W'(r);
    in_col_index <= gmd_pkg::IDX_W'(c);
    in_x_coord   <= x;
    in_y_coord   <= y;
    do @(posedge clk); while (busy !== 1'b0);
    pending_metrics.push_back(predict_metrics(req, gmd_pkg::IDX_W'(r),
                                              gmd_pkg::IDX_W'(c), x, y));
    items_sent++;
  endtask

  task automatic store_point(input int r, input int c);
    send_item(gmd_pkg::REQ_STORE, r, c, rand_coord(), rand_coord());
  endtask

  // Drain all outstanding beats, then leave the block quiet
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_metrics.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [gmd_pkg::DIM_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == gmd_pkg::CFG_IDX_ROWS) rows_reg = val;
    else cols_reg = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(input logic [gmd_pkg::DIM_W-1:0] rows,
                          input logic [gmd_pkg::DIM_W-1:0] cols);
    int unsigned idle_profile [3] = '{0, 61, 8};
    settle();
    write_reg(gmd_pkg::CFG_IDX_ROWS, rows);
    write_reg(gmd_pkg::CFG_IDX_COLS, cols);
    sender_idle_pct = idle_profile[phase_count % 3];
    phase_count++;
  endtask

  // Store (or restore) every point the query reads, then query it
  task automatic probe_point(input int r, input int c);
    int hi, lo, k;
    bit centre;
    int need_r [4], need_c [4];
    if (!is_corner(r, c)) begin
      diff_span(r, rows_in_use(), hi, lo, centre);
      need_r[0] = hi; need_c[0] = c;
      need_r[1] = lo; need_c[1] = c;
      diff_span(c, cols_in_use(), hi, lo, centre);
      need_r[2] = r; need_c[2] = hi;
      need_r[3] = r; need_c[3] = lo;
      for (k = 0; k < 4; k++)
        if (!node_written[node_addr(need_r[k], need_c[k])] || $urandom_range(1) == 0)
          store_point(need_r[k], need_c[k]);
    end
    send_item(gmd_pkg::REQ_QUERY, r, c, $urandom, $urandom);
  endtask

  task automatic traffic_burst(input int n);
    int target, r, c;
    target = items_sent + n;
    while (items_sent < target) begin
      case ($urandom_range(9))
        0: store_point($urandom_range(63), $urandom_range(63));
        1: begin
          // anywhere in the index space; mostly out of range on small grids
          r = $urandom_range(63);
          c = $urandom_range(63);
          if (query_ready(r, c)) send_item(gmd_pkg::REQ_QUERY, r, c, $urandom, $urandom);
          else store_point(r, c);
        end
        2: begin
          r = $urandom_range(1) ? 0 : rows_in_use() - 1;
          c = $urandom_range(1) ? 0 : cols_in_use() - 1;
          send_item(gmd_pkg::REQ_QUERY, r, c, $urandom, $urandom);
        end
        default: probe_point($urandom_range(rows_in_use() - 1),
                             $urandom_range(cols_in_use() - 1));
      endcase
    end
  endtask

  task automatic test_reset_dims();
    // the last index is in range with the reset dimensions
    send_item(gmd_pkg::REQ_STORE, 63, 63, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(gmd_pkg::REQ_QUERY, 63, 63, '0, '1);
  endtask

  task automatic test_small_grid_edges();
    int r, c;
    logic [gmd_pkg::COORD_W-1:0] x, y;
    set_grid(7'd3, 7'd3);
    for (r = 0; r < 3; r++)
      for (c = 0; c < 3; c++) begin
        x = (r == 0) ? 32'h8000_0000 : (r == 2) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
        y = (c == 0) ? 32'h7FFF_FFFF : (c == 2) ? 32'h8000_0000 : 32'h0000_0001;
        send_item(gmd_pkg::REQ_STORE, r, c, x, y);
      end
    // corners, the four side midpoints and the single interior point
    for (r = 0; r < 3; r++)
      for (c = 0; c < 3; c++)
        send_item(gmd_pkg::REQ_QUERY, r, c, '0, '0);
    send_item(gmd_pkg::REQ_QUERY, 3, 0, '0, '0);
    send_item(gmd_pkg::REQ_STORE, 0, 3, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(gmd_pkg::REQ_QUERY, 63, 63, '1, '1);
  endtask

  task automatic test_register_extremes();
    logic [gmd_pkg::DIM_W-1:0] rows_list [6] = '{7'd0, 7'd127, 7'd2, 7'd3, 7'd64, 7'd1};
    logic [gmd_pkg::DIM_W-1:0] cols_list [6] = '{7'd127, 7'd0, 7'd65, 7'd64, 7'd3, 7'd2};
    int k;
    for (k = 0; k < 6; k++) begin
      set_grid(rows_list[k], cols_list[k]);
      traffic_burst(60);
    end
  endtask

  function automatic logic [gmd_pkg::DIM_W-1:0] pick_dim();
    // mostly small grids, now and then a large one
    return ($urandom_range(3) == 0) ? gmd_pkg::DIM_W'($urandom_range(64, 3))
                                    : gmd_pkg::DIM_W'($urandom_range(8, 3));
  endfunction

  task automatic test_random_traffic();
    int k;
    for (k = 0; k < 12; k++) begin
      set_grid(pick_dim(), pick_dim());
      traffic_burst(110);
    end
  endtask

  task automatic check_field(input string name, input logic [gmd_pkg::DERIV_W-1:0] want,
                             input logic [gmd_pkg::DERIV_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%s mismatch at %0t: expected %h, got %h", name, $time, want, got);
    end
  endtask

  always @(posedge clk) begin : check_beat
    metric_beat_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (pending_metrics.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("result beat with nothing expected at %0t", $time);
      end else begin
        want = pending_metrics.pop_front();
        status_seen[int'(want.status)]++;
        check_field("dx_dksi", want.dx_dksi, out_dx_dksi);
        check_field("dy_dksi", want.dy_dksi, out_dy_dksi);
        check_field("dx_deta", want.dx_deta, out_dx_deta);
        check_field("dy_deta", want.dy_deta, out_dy_deta);
        check_field("status", {31'b0, want.status}, {31'b0, out_status});
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    start        = 1'b0;
    in_req_type  = gmd_pkg::REQ_STORE;
    in_row_index = '0;
    in_col_index = '0;
    in_x_coord   = '0;
    in_y_coord   = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_dims();
    test_small_grid_edges();
    test_register_extremes();
    test_random_traffic();
    settle();

    $display("Checked %0d items: %0d stores, %0d metric queries, %0d corners, %0d out of range",
             items_sent, status_seen[gmd_pkg::STAT_STORED], status_seen[gmd_pkg::STAT_VALID],
             status_seen[gmd_pkg::STAT_CORNER], status_seen[gmd_pkg::STAT_RANGE]);
    $display("across %0d grid settings, sender idling at 0, 8 and 61 percent", phase_count);
    if (mismatch_count == 0 && pending_metrics.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d beats outstanding", pending_metrics.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
